@@ hw/rtl/sorted_double_ended_priority_queue_defines.svh @@
// assertion macros for the sorted double-ended priority queue
`ifndef SORTED_DOUBLE_ENDED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_DOUBLE_ENDED_PRIORITY_QUEUE_DEFINES_SVH

// property that holds at every clock edge out of reset
`define SDEPQ_ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// same-cycle implication
`define SDEPQ_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDEPQ_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/sdepq_pkg.sv @@
// types and constants shared by the priority queue modules
package sdepq_pkg;

  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned COUNT_OUT_W = 5;
  localparam int unsigned IN_DATA_W   = 3 * FIELD_W;
  localparam int unsigned OUT_DATA_W  = 104;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH       = 2'd0,
    OP_POP_TOP    = 2'd1,
    OP_POP_BOTTOM = 2'd2,
    OP_READ       = 2'd3
  } op_e;

  // health in the lowest bits
  typedef struct packed {
    logic signed [FIELD_W-1:0] speed;
    logic signed [FIELD_W-1:0] attack;
    logic signed [FIELD_W-1:0] health;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop_top;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/sdepq_cell.sv @@
// one storage cell of the sorted queue chain
module sdepq_cell (
  input  logic                  clk_i,
  input  sdepq_pkg::cell_ctrl_t ctrl_i,
  input  sdepq_pkg::entry_t     new_i,
  input  sdepq_pkg::entry_t     prev_i,
  input  logic                  prev_ins_i,
  input  sdepq_pkg::entry_t     next_i,
  input  logic                  occupied_i,
  input  logic                  is_top_i,
  output sdepq_pkg::entry_t     entry_o,
  output logic                  ins_o
);
  import sdepq_pkg::*;

  entry_t entry_q, entry_d;

  // new entry lands at or above this cell
  assign ins_o = !occupied_i
              || (entry_q.speed < new_i.speed)
              || (!is_top_i && (entry_q.speed == new_i.speed));

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push && ins_o) begin
      entry_d = prev_ins_i ? prev_i : new_i;
    end else if (ctrl_i.pop_top) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ hw/rtl/sorted_double_ended_priority_queue.sv @@
// top level of the sorted double-ended priority queue
//
// Holds up to CAPACITY entries (health, attack, speed) ordered by descending
// speed in a chain of cells; on a push or pop-top all moving cells take a
// neighbor's entry in the same cycle, and a pop-bottom only lowers the count.
// Input beats carry the command in s_axis_tuser and the entry in s_axis_tdata.
// Each accepted beat yields exactly one output beat with both end entries
// (zero when empty), the entry count, an empty flag and a rejected flag
// (push on full or pop on empty, which leave the queue unchanged).
// An input beat passes through the cell update, then the output register;
// one beat per cycle is sustained while the receiver keeps m_axis_tready
// high; the limit is the single result stage between the cells and the
// output register.
// When the receiver stalls, one result waits in the output register and one
// more is held pending; s_axis_tready then drops until the output frees.
// Reset empties the queue and drops any pending result; stored entries are
// not cleared and are never shown until written again.
`include "sorted_double_ended_priority_queue_defines.svh"

module sorted_double_ended_priority_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // entry_health, entry_attack, entry_speed
  input  logic [sdepq_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // operation
  input  logic [sdepq_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // top_health, top_attack, top_speed, bottom_health, bottom_attack,
  // bottom_speed, entry_count, is_empty, rejected, zero pad
  output logic [sdepq_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
  import sdepq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);

  logic [CntW-1:0] count_q, count_d;
  op_e             op;
  entry_t          new_entry;
  logic            in_acc, full, empty, rej_now;
  cell_ctrl_t      ctrl;
  entry_t          cell_e [CAPACITY];
  logic            cell_ins [CAPACITY];

  logic            res_pend_q, res_pend_d;
  logic            rej_q;
  logic            out_valid_q, out_valid_d;
  logic            load_out;

  entry_t              res_top, res_bot;
  logic [IdxW-1:0]     bot_idx;
  logic [CntW+4:0]     cnt_wide;
  logic [COUNT_OUT_W-1:0] res_count;

  entry_t              top_q, bot_q;
  logic [COUNT_OUT_W-1:0] count_out_q;
  logic                empty_out_q, rej_out_q;

  assign op        = op_e'(s_axis_tuser);
  assign new_entry = entry_t'(s_axis_tdata);
  assign full      = (count_q == CntW'(CAPACITY));
  assign empty     = (count_q == '0);
  assign in_acc    = s_axis_tvalid && s_axis_tready;

  always_comb begin
    rej_now      = 1'b0;
    ctrl.push    = 1'b0;
    ctrl.pop_top = 1'b0;
    count_d      = count_q;
    case (op)
      OP_PUSH: begin
        rej_now = full;
        if (in_acc && !full) begin
          ctrl.push = 1'b1;
          count_d   = count_q + 1'b1;
        end
      end
      OP_POP_TOP: begin
        rej_now = empty;
        if (in_acc && !empty) begin
          ctrl.pop_top = 1'b1;
          count_d      = count_q - 1'b1;
        end
      end
      OP_POP_BOTTOM: begin
        rej_now = empty;
        if (in_acc && !empty) begin
          count_d = count_q - 1'b1;
        end
      end
      default: begin
        rej_now = 1'b0;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_ins;

    if (i == 0) begin : g_first
      assign prev_e   = new_entry;
      assign prev_ins = 1'b0;
    end else begin : g_rest
      assign prev_e   = cell_e[i-1];
      assign prev_ins = cell_ins[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_e = cell_e[i];
    end else begin : g_inner
      assign next_e = cell_e[i+1];
    end

    sdepq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .new_i      (new_entry),
      .prev_i     (prev_e),
      .prev_ins_i (prev_ins),
      .next_i     (next_e),
      .occupied_i (count_q > CntW'(i)),
      .is_top_i   (i == 0),
      .entry_o    (cell_e[i]),
      .ins_o      (cell_ins[i])
    );
  end

  // result from the state left by the pending beat
  assign bot_idx   = IdxW'(count_q - 1'b1);
  assign res_top   = empty ? '0 : cell_e[0];
  assign res_bot   = empty ? '0 : cell_e[bot_idx];
  assign cnt_wide  = (CntW + 5)'(count_q);
  assign res_count = cnt_wide[COUNT_OUT_W-1:0];

  assign load_out      = res_pend_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !res_pend_q || load_out;

  always_comb begin
    res_pend_d = res_pend_q;
    if (in_acc) begin
      res_pend_d = 1'b1;
    end else if (load_out) begin
      res_pend_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      res_pend_q  <= res_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rej_q <= rej_now;
    end
    if (load_out) begin
      top_q       <= res_top;
      bot_q       <= res_bot;
      count_out_q <= res_count;
      empty_out_q <= empty;
      rej_out_q   <= rej_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, rej_out_q, empty_out_q, count_out_q,
                          bot_q.speed, bot_q.attack, bot_q.health,
                          top_q.speed, top_q.attack, top_q.health};

  `SDEPQ_ASSERT_ALWAYS(a_count_bound, count_q <= CntW'(CAPACITY), "count above capacity")
  `SDEPQ_ASSERT_NEXT(a_push_grows, ctrl.push, count_q == CntW'($past(count_q) + 1'b1), "push lost")
  `SDEPQ_ASSERT_IMPL(a_no_overrun, in_acc && res_pend_q, load_out, "pending result overwritten")

endmodule
